[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. All sample on the rising clock edge
// and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rmv_pkg.sv]
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared widths, sequencer states and unit status type for the running
// mean and variance block.
// ----------------------------------------------------------------------------
package rmv_pkg;

   localparam int COUNT_BITS  = 32;
   localparam int SAMPLE_BITS = 32;
   localparam int SUM_BITS    = 48;
   localparam int DEV_BITS    = SAMPLE_BITS + 1;
   localparam int DVD_BITS    = 64;
   localparam int STEP_BITS   = 7;
   localparam int MUL_STEPS   = DEV_BITS;
   localparam int ROOT_STEPS  = DVD_BITS / 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_VAR_GO,
      ST_VAR_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

[rtl/rmv_divider.sv]
// ----------------------------------------------------------------------------
// rmv_divider
// Restoring divider, one quotient bit per cycle. The dividend arrives
// left-aligned so that only the requested number of steps run.
// ----------------------------------------------------------------------------
module rmv_divider
   import rmv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DVD_BITS-1:0]   dividend,
   input  logic [COUNT_BITS-1:0] divisor,
   input  logic [STEP_BITS-1:0]  steps,
   output logic [DVD_BITS-1:0]   quotient,
   output unit_stat_type         stat
);

   logic [DVD_BITS-1:0]   dvd_ff;
   logic [COUNT_BITS-1:0] rem_ff;
   logic [COUNT_BITS-1:0] dsr_ff;
   logic [STEP_BITS-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [COUNT_BITS:0]   shifted;
   logic                  fits;

   assign shifted = {rem_ff, dvd_ff[DVD_BITS-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[DVD_BITS-2:0], fits};
         rem_ff <= fits ? COUNT_BITS'(shifted - {1'b0, dsr_ff}) : shifted[COUNT_BITS-1:0];
      end
   end

   assign quotient = dvd_ff;
   assign stat     = '{busy: busy_ff, done: done_ff};

endmodule

[rtl/rmv_multiplier.sv]
// ----------------------------------------------------------------------------
// rmv_multiplier
// Shift-add multiplier for the two deviation magnitudes, one multiplier
// bit per cycle.
// ----------------------------------------------------------------------------
module rmv_multiplier
   import rmv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DEV_BITS-1:0] op_a,
   input  logic [DEV_BITS-1:0] op_b,
   output logic [DVD_BITS-1:0] product,
   output unit_stat_type       stat
);

   logic [DVD_BITS-1:0]  acc_ff;
   logic [DVD_BITS-1:0]  mcand_ff;
   logic [DEV_BITS-1:0]  mplier_ff;
   logic [STEP_BITS-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_BITS'(MUL_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= DVD_BITS'(op_a);
         mplier_ff <= op_b;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[DVD_BITS-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[DEV_BITS-1:1]};
      end
   end

   assign product = acc_ff;
   assign stat    = '{busy: busy_ff, done: done_ff};

endmodule

[rtl/rmv_sqrt.sv]
// ----------------------------------------------------------------------------
// rmv_sqrt
// Digit-by-digit floored square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rmv_sqrt
   import rmv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DVD_BITS-1:0]   radicand,
   output logic [ROOT_STEPS-1:0] root,
   output unit_stat_type         stat
);

   localparam int REM_BITS = ROOT_STEPS + 2;

   logic [DVD_BITS-1:0]   rad_ff;
   logic [REM_BITS-1:0]   rem_ff;
   logic [ROOT_STEPS-1:0] root_ff;
   logic [STEP_BITS-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [REM_BITS+1:0]   partial;
   logic [REM_BITS+1:0]   trial;
   logic                  fits;

   assign partial = {rem_ff, rad_ff[DVD_BITS-1 -: 2]};
   assign trial   = (REM_BITS+2)'({root_ff, 2'b01});
   assign fits    = partial >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_BITS'(ROOT_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[DVD_BITS-3:0], 2'b00};
         rem_ff  <= fits ? REM_BITS'(partial - trial) : REM_BITS'(partial);
         root_ff <= {root_ff[ROOT_STEPS-2:0], fits};
      end
   end

   assign root = root_ff;
   assign stat = '{busy: busy_ff, done: done_ff};

endmodule

[rtl/running_mean_variance.sv]
// ----------------------------------------------------------------------------
// running_mean_variance
// Welford running mean / variance over signed fixed-point samples.
//
// Usage: present a sample on req_sample with req_valid; it is taken when
// req_ready is also high. Each request yields one response on the rsp_
// channel with count, saturating sum, mean, sample variance and the floored
// standard deviation after that sample.
// Sequence: a first sample goes straight to the done state, which loads its
// response into the output register. Every later sample runs a 33-step mean
// division, a 33-step deviation multiply, a 64-step variance division and a
// 32-step square root on shift-register units, each one bit (root: two bits)
// per cycle; both divisions share one divider, multiply and root own theirs.
// One request is in flight at a time; req_ready is high in idle, so the next
// request is taken once the done state has loaded the previous response.
// Stall: a finished response sits in the output register until rsp_ready;
// the next request is taken meanwhile, and its result waits if the
// register is still full.
// Reset clears count, sum, mean and squared deviations and empties the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module running_mean_variance
   import rmv_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [31:0]                  rsp_count,
   output logic signed [SUM_BITS-1:0]   rsp_total,
   output logic signed [31:0]           rsp_mean,
   output logic [63:0]                  rsp_variance,
   output logic [31:0]                  rsp_std_dev
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic signed [SUM_BITS:0] SUM_HI = (SUM_BITS+1)'({1'b0, {(SUM_BITS-1){1'b1}}});
   localparam logic signed [SUM_BITS:0] SUM_LO = -SUM_HI - 1;

   state_type state_ff, state_in;

   // statistics
   logic [COUNT_BITS-1:0]         count_ff, count_in;
   logic signed [SUM_BITS-1:0]    sum_ff;
   logic signed [SAMPLE_BITS-1:0] mean_ff;
   logic [DVD_BITS-1:0]           devsq_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic [DEV_BITS-1:0]           dold_mag_ff;
   logic                          dold_neg_ff;
   logic [DVD_BITS-1:0]           var_ff;
   logic [ROOT_STEPS-1:0]         std_ff;

   // output register
   logic                          rsp_valid_ff;
   logic [31:0]                   rsp_count_ff;
   logic signed [SUM_BITS-1:0]    rsp_total_ff;
   logic signed [31:0]            rsp_mean_ff;
   logic [63:0]                   rsp_variance_ff;
   logic [31:0]                   rsp_std_dev_ff;

   logic req_take;
   logic out_free;
   logic div_start, mul_start, root_start;
   logic [DVD_BITS-1:0]   div_dividend;
   logic [COUNT_BITS-1:0] div_divisor;
   logic [STEP_BITS-1:0]  div_steps;
   logic [DVD_BITS-1:0]   div_quot;
   logic [DVD_BITS-1:0]   mul_prod;
   logic [ROOT_STEPS-1:0] root_val;
   unit_stat_type         div_stat, mul_stat, root_stat;

   logic signed [SUM_BITS:0]      sum_wide;
   logic signed [DEV_BITS-1:0]    d_old;
   logic signed [DEV_BITS:0]      mean_next_wide;
   logic signed [DEV_BITS-1:0]    d_new;
   logic [DEV_BITS-1:0]           d_new_mag;
   logic [DVD_BITS:0]             devsq_sum;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // count saturates at its maximum
   assign count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
   assign sum_wide = (SUM_BITS+1)'(sum_ff) + (SUM_BITS+1)'(req_sample);

   // deviation from the old mean, and the mean moved by the quotient
   assign d_old = DEV_BITS'(x_ff) - DEV_BITS'(mean_ff);
   assign mean_next_wide = dold_neg_ff
      ? (DEV_BITS+1)'(mean_ff) - (DEV_BITS+1)'(div_quot[DEV_BITS-1:0])
      : (DEV_BITS+1)'(mean_ff) + (DEV_BITS+1)'(div_quot[DEV_BITS-1:0]);
   assign d_new     = DEV_BITS'(x_ff) - DEV_BITS'(mean_ff);
   assign d_new_mag = d_new[DEV_BITS-1] ? DEV_BITS'(-d_new) : DEV_BITS'(d_new);
   assign devsq_sum = {1'b0, devsq_ff} + {1'b0, mul_prod};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_take) state_in = (count_in == COUNT_BITS'(1)) ? ST_DONE
                                                                             : ST_MEAN_GO;
         ST_MEAN_GO:   state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: if (div_stat.done) state_in = ST_MUL_GO;
         ST_MUL_GO:    state_in = ST_MUL_WAIT;
         ST_MUL_WAIT:  if (mul_stat.done) state_in = ST_VAR_GO;
         ST_VAR_GO:    state_in = ST_VAR_WAIT;
         ST_VAR_WAIT:  if (div_stat.done) state_in = ST_ROOT_GO;
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (root_stat.done) state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // unit controls
   always_comb begin
      div_start    = 1'b0;
      mul_start    = 1'b0;
      root_start   = 1'b0;
      div_dividend = devsq_ff;
      div_divisor  = count_ff - 1'b1;
      div_steps    = STEP_BITS'(DVD_BITS);
      unique case (state_ff)
         ST_MEAN_GO: begin
            div_start    = 1'b1;
            div_dividend = {(d_old[DEV_BITS-1] ? DEV_BITS'(-d_old) : DEV_BITS'(d_old)),
                            {(DVD_BITS-DEV_BITS){1'b0}}};
            div_divisor  = count_ff;
            div_steps    = STEP_BITS'(DEV_BITS);
         end
         ST_MUL_GO:  mul_start  = 1'b1;
         ST_VAR_GO:  div_start  = 1'b1;
         ST_ROOT_GO: root_start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         mean_ff  <= '0;
         devsq_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (req_take) begin
            count_ff <= count_in;
            if (sum_wide > SUM_HI)      sum_ff <= SUM_HI[SUM_BITS-1:0];
            else if (sum_wide < SUM_LO) sum_ff <= SUM_LO[SUM_BITS-1:0];
            else                        sum_ff <= sum_wide[SUM_BITS-1:0];
            if (count_in == COUNT_BITS'(1)) mean_ff <= req_sample;
         end
         if (state_ff == ST_MEAN_WAIT && div_stat.done) begin
            mean_ff <= mean_next_wide[SAMPLE_BITS-1:0];
         end
         if (state_ff == ST_MUL_WAIT && mul_stat.done) begin
            devsq_ff <= devsq_sum[DVD_BITS] ? '1 : devsq_sum[DVD_BITS-1:0];
         end
      end
   end

   // per-request working values
   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff   <= req_sample;
         var_ff <= '0;
         std_ff <= '0;
      end
      if (state_ff == ST_MEAN_GO) begin
         dold_neg_ff <= d_old[DEV_BITS-1];
         dold_mag_ff <= d_old[DEV_BITS-1] ? DEV_BITS'(-d_old) : DEV_BITS'(d_old);
      end
      if (state_ff == ST_VAR_WAIT && div_stat.done) var_ff <= div_quot;
      if (state_ff == ST_ROOT_WAIT && root_stat.done) std_ff <= root_val;
   end

   // output register: load in done, drop on handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_count_ff    <= 32'(count_ff);
         rsp_total_ff    <= sum_ff;
         rsp_mean_ff     <= 32'(mean_ff);
         rsp_variance_ff <= 64'(var_ff);
         rsp_std_dev_ff  <= 32'(std_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_total    = rsp_total_ff;
   assign rsp_mean     = rsp_mean_ff;
   assign rsp_variance = rsp_variance_ff;
   assign rsp_std_dev  = rsp_std_dev_ff;

   rmv_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .steps    (div_steps),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   rmv_multiplier u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (dold_mag_ff),
      .op_b    (d_new_mag),
      .product (mul_prod),
      .stat    (mul_stat)
   );

   rmv_sqrt u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (var_ff),
      .root     (root_val),
      .stat     (root_stat)
   );

   `ASSERT_NOW(a_rsp_count_nonzero, rsp_valid, rsp_count != 32'd0, "response with zero count")
   `ASSERT_NOW(a_low_count_zero_var, rsp_valid && rsp_count < 32'd2,
               rsp_variance == 64'd0 && rsp_std_dev == 32'd0, "variance below two samples")
   `ASSERT_NEXT(a_take_leaves_idle, req_valid && req_ready, !req_ready, "request not started")
   `ASSERT_NEXT(a_load_only_done, !(state_ff == ST_DONE && out_free) && !rsp_valid,
                !rsp_valid, "response appeared outside done")

endmodule
